[src/pinhole_point_projection_core_assert.svh]
// Assertion macros shared by the pinhole point projection RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef PINHOLE_POINT_PROJECTION_CORE_ASSERT_SVH
`define PINHOLE_POINT_PROJECTION_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PPP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define PPP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ppp_pkg.sv]
// Package for the pinhole point projection core: widths, store layout and
// the structs passed between the sequencer, the MAC unit and the divider.
package ppp_pkg;

  localparam int unsigned DataW           = 32;
  localparam int unsigned IdxW            = 5;
  localparam int unsigned RowW            = 3;
  localparam int unsigned TermW           = 2;
  localparam int unsigned FractionBitsDef = 16;

  // Coefficient store layout.
  localparam int unsigned CoefCount = 21;
  localparam int unsigned CamBase   = 0;
  localparam int unsigned RotBase   = 9;
  localparam int unsigned TransBase = 18;
  localparam int unsigned RowTerms  = 3;

  // Item kinds.
  localparam logic KindLoad  = 1'b0;
  localparam logic KindPoint = 1'b1;

  // Rows 0-2 are the rotation rows, rows 3-5 the camera rows.
  localparam logic [RowW-1:0]  CamRow0     = 3'd3;
  localparam logic [RowW-1:0]  LastRow     = 3'd5;
  // The fourth rotation term carries the translation.
  localparam logic [TermW-1:0] UnitTerm    = 2'd3;
  localparam logic [TermW-1:0] LastCamTerm = 2'd2;

  // Tag that travels with one multiply-accumulate term.
  typedef struct packed {
    logic            vld;
    logic            last;
    logic [RowW-1:0] row;
  } ppp_tag_t;

  // One finished, clamped row of a matrix-vector product.
  typedef struct packed {
    logic                    vld;
    logic [RowW-1:0]         row;
    logic signed [DataW-1:0] value;
    logic                    sat;
  } ppp_res_t;

  // Divider status and result.
  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [DataW-1:0] quot;
    logic                    sat;
  } ppp_div_stat_t;

endpackage

[src/ppp_if.sv]
// Valid/ready channel interfaces for the pinhole point projection core.
// Depends on ppp_pkg for field widths.
interface ppp_in_if import ppp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [IdxW-1:0]         coef_index;
  logic signed [DataW-1:0] coef_value;
  logic signed [DataW-1:0] point_x;
  logic signed [DataW-1:0] point_y;
  logic signed [DataW-1:0] point_z;

  modport source (
    output valid, kind, coef_index, coef_value, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, kind, coef_index, coef_value, point_x, point_y, point_z,
    output ready
  );
endinterface

interface ppp_out_if import ppp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] pixel_x;
  logic signed [DataW-1:0] pixel_y;
  logic                    zero_depth;
  logic                    saturated;

  modport source (
    output valid, pixel_x, pixel_y, zero_depth, saturated,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, zero_depth, saturated,
    output ready
  );
endinterface

[src/ppp_mac.sv]
// Shared multiply-accumulate unit: one 32x32 product per cycle, a 66-bit
// accumulator, then floor shift and clamp at the end of a row. Uses ppp_pkg.
module ppp_mac import ppp_pkg::*; #(
  parameter int unsigned FractionBits = FractionBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ppp_tag_t                tag_i,
  input  logic signed [DataW-1:0] coef_i,
  input  logic signed [DataW-1:0] opnd_i,
  output ppp_res_t                res_o
);

  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned AccW  = ProdW + 2;

  logic signed [ProdW-1:0] prod_d, prod_q;
  ppp_tag_t                btag_q;
  logic signed [AccW-1:0]  acc_q, sum, shifted;
  logic                    pos_ovf, neg_ovf;
  logic signed [DataW-1:0] clamped;
  ppp_res_t                res_q;

  assign prod_d = coef_i * opnd_i;

  always_comb begin
    sum     = acc_q + AccW'(prod_q);
    shifted = sum >>> FractionBits;
    pos_ovf = !shifted[AccW-1] && (|shifted[AccW-2:DataW-1]);
    neg_ovf = shifted[AccW-1] && !(&shifted[AccW-2:DataW-1]);
    if (pos_ovf) begin
      clamped = {1'b0, {(DataW-1){1'b1}}};
    end else if (neg_ovf) begin
      clamped = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      clamped = shifted[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btag_q <= '0;
      acc_q  <= '0;
      res_q  <= '0;
    end else begin
      btag_q    <= tag_i;
      res_q.vld <= 1'b0;
      if (btag_q.vld) begin
        if (btag_q.last) begin
          acc_q       <= '0;
          res_q.vld   <= 1'b1;
          res_q.row   <= btag_q.row;
          res_q.value <= clamped;
          res_q.sat   <= pos_ovf || neg_ovf;
        end else begin
          acc_q <= sum;
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

[src/ppp_div.sv]
// Restoring radix-2 divider for (a * 2^F) / b, truncating toward zero and
// clamping to 32 bits. One quotient bit per cycle. Uses ppp_pkg.
module ppp_div import ppp_pkg::*; #(
  parameter int unsigned FractionBits = FractionBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DataW-1:0] dividend_i,
  input  logic signed [DataW-1:0] divisor_i,
  output ppp_div_stat_t           stat_o
);

  localparam int unsigned NumW = DataW + FractionBits;
  localparam int unsigned CntW = $clog2(NumW);

  logic                busy_q, fix_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [NumW-1:0]     num_q;
  logic [DataW-1:0]    rem_q, den_q;
  logic                neg_q, sat_q;
  logic signed [DataW-1:0] quot_q;

  logic [DataW-1:0] mag_a, mag_b;
  logic [DataW:0]   trial, diff;
  logic             ge;
  logic             hi_any, big;
  logic [DataW-1:0] quot_d;

  always_comb begin
    mag_a  = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
    mag_b  = divisor_i[DataW-1] ? (~divisor_i + 1'b1) : divisor_i;
    trial  = {rem_q, num_q[NumW-1]};
    diff   = trial - {1'b0, den_q};
    ge     = trial >= {1'b0, den_q};
    hi_any = |num_q[NumW-1:DataW];
    if (neg_q) begin
      big    = hi_any || (num_q[DataW-1] && (|num_q[DataW-2:0]));
      quot_d = big ? {1'b1, {(DataW-1){1'b0}}} : (~num_q[DataW-1:0] + 1'b1);
    end else begin
      big    = hi_any || num_q[DataW-1];
      quot_d = big ? {1'b0, {(DataW-1){1'b1}}} : num_q[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fix_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end else if (fix_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= NumW'(mag_a) << FractionBits;
      den_q <= mag_b;
      rem_q <= '0;
      neg_q <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], ge};
      rem_q <= ge ? diff[DataW-1:0] : trial[DataW-1:0];
    end
    if (fix_q) begin
      quot_q <= quot_d;
      sat_q  <= big;
    end
  end

  assign stat_o = '{busy: busy_q || fix_q, done: done_q, quot: quot_q, sat: sat_q};

endmodule

[src/pinhole_point_projection_core.sv]
// Top level of the pinhole point projection core: coefficient store,
// sequencer and result register. Depends on ppp_pkg, ppp_if, ppp_mac, ppp_div.
//
//   Channel | Dir | Beat payload
//   --------+-----+----------------------------------------------------------
//   in_i    | in  | kind, coef_index, coef_value, point_x, point_y, point_z
//   out_o   | out | pixel_x, pixel_y, zero_depth, saturated
//
// A load beat writes the coefficient store and leaves the core ready for the
// next beat. A point beat runs 21 multiply-accumulate terms through the single
// shared multiplier, then, unless the depth is zero, two divisions of
// 32+FRACTION_BITS steps each in the bit-serial divider. Reset clears all
// control state; the coefficient store is undefined until loaded. While a
// result waits on out_o the core still accepts the next beat and only holds
// before writing the output register.
`include "pinhole_point_projection_core_assert.svh"

module pinhole_point_projection_core import ppp_pkg::*; #(
  parameter int unsigned FractionBits = FractionBitsDef
) (
  input logic   clk_i,
  input logic   rst_ni,
  ppp_in_if.sink    in_i,
  ppp_out_if.source out_o
);

  // The translation rides through the multiplier as T * 2^F, so that the
  // floor shift of the whole row sum adds T exactly.
  localparam logic signed [DataW-1:0] UnitVal = DataW'(64'd1 << FractionBits);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_CHECK,
    S_DIV0,
    S_DIV1,
    S_OUT
  } state_e;

  state_e state_q;
  logic [RowW-1:0]  row_q;
  logic [TermW-1:0] term_q;
  logic             out_vld_q, sat_q, zero_q;
  ppp_tag_t         a_tag_q, tag_d;

  logic signed [DataW-1:0] coef_mem [CoefCount];
  logic signed [DataW-1:0] coef_rd_q;
  logic [TermW-1:0]        a_term_q;
  logic                    a_cam_q;
  logic signed [DataW-1:0] p_q [3];
  logic signed [DataW-1:0] q_q [3];
  logic signed [DataW-1:0] s_q [3];
  logic signed [DataW-1:0] px_q, py_q;
  logic signed [DataW-1:0] pix_x_q, pix_y_q;
  logic                    zero_o_q, sat_o_q;

  logic                    in_ready, in_acc, pt_acc, load_we, out_free;
  logic                    is_cam, issue_last;
  logic [IdxW-1:0]         row_x3, rd_addr;
  logic signed [DataW-1:0] opnd;
  logic                    div_start;
  logic signed [DataW-1:0] div_num;
  ppp_res_t                mac_res;
  ppp_div_stat_t           div_stat;

  // Handshake and issue control.
  always_comb begin
    in_ready   = (state_q == S_IDLE);
    in_acc     = in_i.valid && in_ready;
    pt_acc     = in_acc && (in_i.kind == KindPoint);
    load_we    = in_acc && (in_i.kind == KindLoad) && (in_i.coef_index < IdxW'(CoefCount));
    out_free   = !out_vld_q || out_o.ready;
    is_cam     = (row_q >= CamRow0);
    issue_last = is_cam ? (term_q == LastCamTerm) : (term_q == UnitTerm);
    row_x3     = IdxW'({row_q, 1'b0}) + IdxW'(row_q);
    if (is_cam) begin
      rd_addr = row_x3 - IdxW'(RowTerms * CamRow0) + IdxW'(CamBase) + IdxW'(term_q);
    end else if (term_q == UnitTerm) begin
      rd_addr = IdxW'(TransBase) + IdxW'(row_q);
    end else begin
      rd_addr = IdxW'(RotBase) + row_x3 + IdxW'(term_q);
    end
    tag_d = '{vld: (state_q == S_MAC), last: issue_last, row: row_q};
  end

  // Operand for the term whose coefficient is now in coef_rd_q.
  always_comb begin
    if (a_cam_q) begin
      case (a_term_q)
        2'd0:    opnd = q_q[0];
        2'd1:    opnd = q_q[1];
        default: opnd = q_q[2];
      endcase
    end else begin
      case (a_term_q)
        2'd0:    opnd = p_q[0];
        2'd1:    opnd = p_q[1];
        2'd2:    opnd = p_q[2];
        default: opnd = UnitVal;
      endcase
    end
  end

  // The first division starts once depth is known to be nonzero, the second
  // in the cycle the first one reports done.
  always_comb begin
    div_start = ((state_q == S_CHECK) && (s_q[2] != '0)) ||
                ((state_q == S_DIV0) && div_stat.done);
    div_num   = (state_q == S_CHECK) ? s_q[0] : s_q[1];
  end

  // Coefficient store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      coef_mem[in_i.coef_index] <= in_i.coef_value;
    end
    coef_rd_q <= coef_mem[rd_addr];
  end

  ppp_mac #(
    .FractionBits(FractionBits)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (a_tag_q),
    .coef_i (coef_rd_q),
    .opnd_i (opnd),
    .res_o  (mac_res)
  );

  ppp_div #(
    .FractionBits(FractionBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (s_q[2]),
    .stat_o     (div_stat)
  );

  // Sequencer, together with the output register it loads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_q     <= '0;
      term_q    <= '0;
      a_tag_q   <= '0;
      out_vld_q <= 1'b0;
      sat_q     <= 1'b0;
      zero_q    <= 1'b0;
      pix_x_q   <= '0;
      pix_y_q   <= '0;
      zero_o_q  <= 1'b0;
      sat_o_q   <= 1'b0;
    end else begin
      a_tag_q <= tag_d;
      if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (mac_res.vld && mac_res.sat) begin
        sat_q <= 1'b1;
      end
      if (div_stat.done && div_stat.sat) begin
        sat_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (pt_acc) begin
            state_q <= S_MAC;
            row_q   <= '0;
            term_q  <= '0;
            sat_q   <= 1'b0;
            zero_q  <= 1'b0;
          end
        end
        S_MAC: begin
          if (issue_last) begin
            term_q <= '0;
            if (row_q == LastRow) begin
              state_q <= S_DRAIN;
            end else begin
              row_q <= row_q + 1'b1;
            end
          end else begin
            term_q <= term_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (mac_res.vld && (mac_res.row == LastRow)) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (s_q[2] == '0) begin
            zero_q  <= 1'b1;
            state_q <= S_OUT;
          end else begin
            state_q <= S_DIV0;
          end
        end
        S_DIV0: begin
          if (div_stat.done) begin
            state_q <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_stat.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            pix_x_q   <= zero_q ? '0 : px_q;
            pix_y_q   <= zero_q ? '0 : py_q;
            zero_o_q  <= zero_q;
            sat_o_q   <= sat_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a_term_q <= term_q;
    a_cam_q  <= is_cam;
    if (pt_acc) begin
      p_q[0] <= in_i.point_x;
      p_q[1] <= in_i.point_y;
      p_q[2] <= in_i.point_z;
    end
    if (mac_res.vld) begin
      if (mac_res.row < CamRow0) begin
        q_q[mac_res.row[TermW-1:0]] <= mac_res.value;
      end else begin
        s_q[TermW'(mac_res.row - CamRow0)] <= mac_res.value;
      end
    end
    if ((state_q == S_DIV0) && div_stat.done) begin
      px_q <= div_stat.quot;
    end
    if ((state_q == S_DIV1) && div_stat.done) begin
      py_q <= div_stat.quot;
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_vld_q;
  assign out_o.pixel_x    = pix_x_q;
  assign out_o.pixel_y    = pix_y_q;
  assign out_o.zero_depth = zero_o_q;
  assign out_o.saturated  = sat_o_q;

  // A zero-depth result always carries zero pixels.
  `PPP_ASSERT(a_zero_depth_pixels,
              (out_o.valid && out_o.zero_depth) |-> (out_o.pixel_x == '0 && out_o.pixel_y == '0),
              "zero depth result with nonzero pixel")
  // The divider only runs while the sequencer waits on it.
  `PPP_ASSERT(a_div_owned,
              div_stat.busy |-> (state_q == S_DIV0 || state_q == S_DIV1),
              "divider busy outside a division state")
  // The MAC pipeline is empty whenever the core is idle.
  `PPP_ASSERT(a_mac_drained,
              (state_q == S_IDLE) |-> (!a_tag_q.vld && !mac_res.vld),
              "MAC activity while idle")
  // A point beat makes the core busy in the next cycle.
  `PPP_ASSERT_NEXT(a_point_busy, pt_acc, !in_i.ready, "ready right after a point beat")

endmodule

[bench/pinhole_point_projection_core_tb.sv]
// Self-checking testbench for pinhole_point_projection_core: coefficient loads
// and point beats go in, projected pixels are predicted and compared beat by beat.
// Depends on ppp_pkg, the ppp_in_if/ppp_out_if interfaces and the core RTL.
module pinhole_point_projection_core_tb;
  import ppp_pkg::*;

  localparam int unsigned FracBits     = FractionBitsDef;
  localparam int unsigned WideW        = 3 * DataW;
  localparam int unsigned ClkHalf      = 6;
  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned RandomBeats  = 1550;
  localparam int unsigned CalmBeats    = 150;
  localparam int unsigned DrainCycles  = 400;
  localparam longint      TimeoutTicks = 64'd12_000_000;

  localparam logic signed [DataW-1:0] One    = 32'sd1 <<< FracBits;
  localparam logic signed [DataW-1:0] MaxVal = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] MinVal = 32'sh8000_0000;

  // Payload of one input beat, as the host presents it.
  typedef struct {
    logic                    kind;
    logic [IdxW-1:0]         coef_index;
    logic signed [DataW-1:0] coef_value;
    logic signed [DataW-1:0] point_x;
    logic signed [DataW-1:0] point_y;
    logic signed [DataW-1:0] point_z;
  } proj_beat_t;

  // Payload of one output beat.
  typedef struct {
    logic signed [DataW-1:0] pixel_x;
    logic signed [DataW-1:0] pixel_y;
    logic                    zero_depth;
    logic                    saturated;
  } pixel_result_t;

  // The scoreboard keeps its own copy of the coefficient store and computes
  // the pixel for every accepted point beat. Expected pixels queue up in
  // acceptance order, since the core answers points strictly in order.
  class pixel_scoreboard;
    logic signed [DataW-1:0] coef_q [CoefCount];
    pixel_result_t           pending_q [$];
    int unsigned             fail_count;
    bit                      clamp_hit;

    function new();
      fail_count = 0;
      foreach (coef_q[i]) coef_q[i] = '0;
    endfunction

    function logic signed [WideW-1:0] widen(logic signed [DataW-1:0] a);
      return a;
    endfunction

    // Saturate a wide value to 32 signed bits and remember that it happened.
    function logic signed [DataW-1:0] clamp_wide(logic signed [WideW-1:0] v);
      if (v[WideW-1:DataW-1] != {(WideW-DataW+1){v[WideW-1]}}) begin
        clamp_hit = 1'b1;
        return v[WideW-1] ? MinVal : MaxVal;
      end
      return v[DataW-1:0];
    endfunction

    // One matrix row times a vector: exact sum of products, floored shift
    // back to the fixed-point format, plus the offset term, then clamped.
    function logic signed [DataW-1:0] row_product(int unsigned base,
                                                  logic signed [DataW-1:0] v0,
                                                  logic signed [DataW-1:0] v1,
                                                  logic signed [DataW-1:0] v2,
                                                  logic signed [DataW-1:0] offset);
      logic signed [WideW-1:0] acc;
      acc = widen(coef_q[base]) * widen(v0) + widen(coef_q[base+1]) * widen(v1) +
            widen(coef_q[base+2]) * widen(v2);
      acc = (acc >>> FracBits) + widen(offset);
      return clamp_wide(acc);
    endfunction

    function pixel_result_t project(logic signed [DataW-1:0] px,
                                    logic signed [DataW-1:0] py,
                                    logic signed [DataW-1:0] pz);
      logic signed [DataW-1:0] q0, q1, q2, s0, s1, s2;
      pixel_result_t           r;
      clamp_hit = 1'b0;
      q0 = row_product(RotBase,     px, py, pz, coef_q[TransBase]);
      q1 = row_product(RotBase + 3, px, py, pz, coef_q[TransBase+1]);
      q2 = row_product(RotBase + 6, px, py, pz, coef_q[TransBase+2]);
      s0 = row_product(CamBase,     q0, q1, q2, '0);
      s1 = row_product(CamBase + 3, q0, q1, q2, '0);
      s2 = row_product(CamBase + 6, q0, q1, q2, '0);
      if (s2 == '0) begin
        r.pixel_x    = '0;
        r.pixel_y    = '0;
        r.zero_depth = 1'b1;
      end else begin
        // Signed division in SystemVerilog truncates toward zero.
        r.pixel_x    = clamp_wide((widen(s0) <<< FracBits) / widen(s2));
        r.pixel_y    = clamp_wide((widen(s1) <<< FracBits) / widen(s2));
        r.zero_depth = 1'b0;
      end
      r.saturated = clamp_hit;
      return r;
    endfunction

    function void note_beat(proj_beat_t b);
      if (b.kind == KindLoad) begin
        if (b.coef_index < CoefCount) coef_q[b.coef_index] = b.coef_value;
      end else begin
        pending_q.insert(pending_q.size(), project(b.point_x, b.point_y, b.point_z));
      end
    endfunction

    function void compare_field(string field, logic signed [DataW-1:0] want,
                                logic signed [DataW-1:0] got);
      if (got !== want) begin
        fail_count++;
        $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                 $time, field, want, want, got, got);
      end
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pending_q.size() == 0) begin
        fail_count++;
        $display("%0t: pixel beat with nothing expected, actual x=%0d y=%0d zd=%0b sat=%0b",
                 $time, got.pixel_x, got.pixel_y, got.zero_depth, got.saturated);
        return;
      end
      want = pending_q.pop_front();
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("zero_depth", want.zero_depth, got.zero_depth);
      compare_field("saturated", want.saturated, got.saturated);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  // Set near the end of the random part: from then on neither side idles,
  // so the core also sees back-to-back beats with an always-ready sink.
  bit              calm = 1'b0;
  int unsigned     beats_done;
  pixel_scoreboard board = new();

  ppp_in_if  in_if ();
  ppp_out_if out_if ();

  pinhole_point_projection_core #(
    .FractionBits(FracBits)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // Offer one beat and hold it until the core takes it. A random idle burst
  // may come first; valid is only ever assigned once per time step, so a
  // beat that follows an accepted one keeps valid high without a glitch.
  task automatic send_beat(input proj_beat_t b);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.kind       <= b.kind;
    in_if.coef_index <= b.coef_index;
    in_if.coef_value <= b.coef_value;
    in_if.point_x    <= b.point_x;
    in_if.point_y    <= b.point_y;
    in_if.point_z    <= b.point_z;
    in_if.valid      <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_beat(b);
    if (b.kind == KindPoint || b.coef_index < CoefCount) beats_done++;
  endtask

  // The point fields of a load beat are don't-care, so they carry noise.
  task automatic load_coef(input int unsigned idx, input logic signed [DataW-1:0] value);
    proj_beat_t b;
    b.kind       = KindLoad;
    b.coef_index = idx[IdxW-1:0];
    b.coef_value = value;
    b.point_x    = $urandom;
    b.point_y    = $urandom;
    b.point_z    = $urandom;
    send_beat(b);
  endtask

  // Likewise the coefficient fields of a point beat are noise.
  task automatic project_point(input logic signed [DataW-1:0] x,
                               input logic signed [DataW-1:0] y,
                               input logic signed [DataW-1:0] z);
    proj_beat_t b;
    b.kind       = KindPoint;
    b.coef_index = $urandom_range(0, 31);
    b.coef_value = $urandom;
    b.point_x    = x;
    b.point_y    = y;
    b.point_z    = z;
    send_beat(b);
  endtask

  // Mostly modest values so that projections land in range, with full-range
  // words and the corner values mixed in to reach every clamp.
  function automatic logic signed [DataW-1:0] pick_value(int unsigned spread);
    int unsigned lim;
    lim = 1 << spread;
    case ($urandom_range(0, 9))
      6, 7: return $urandom;
      8, 9: begin
        case ($urandom_range(0, 5))
          0:       return MinVal;
          1:       return MaxVal;
          2:       return '0;
          3:       return -1;
          4:       return One;
          default: return -One;
        endcase
      end
      default: return $urandom_range(0, 2 * lim - 1) - lim;
    endcase
  endfunction

  // Camera matrix reload. Half of the reloads are a proper pinhole matrix with
  // focal length and principal point; some are arbitrary, and some have a
  // zero third row so that every point of the group hits zero depth.
  task automatic load_camera();
    logic signed [DataW-1:0] cam [9];
    logic signed [DataW-1:0] focal;
    int unsigned             mode;
    mode  = $urandom_range(0, 3);
    focal = $urandom_range(1, 1024) << FracBits;
    foreach (cam[k]) cam[k] = pick_value(18);
    if (mode <= 1) begin
      cam = '{focal, '0, $urandom_range(0, 640) << FracBits,
              '0, focal, $urandom_range(0, 480) << FracBits,
              '0, '0, One};
    end else if (mode == 3) begin
      cam[6] = '0;
      cam[7] = '0;
      cam[8] = '0;
    end
    foreach (cam[k]) load_coef(CamBase + k, cam[k]);
  endtask

  initial begin : stimulus
    int unsigned idx;
    in_if.valid      <= 1'b0;
    in_if.kind       <= KindLoad;
    in_if.coef_index <= '0;
    in_if.coef_value <= '0;
    in_if.point_x    <= '0;
    in_if.point_y    <= '0;
    in_if.point_z    <= '0;
    rst_n            <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Every store entry is written before the first point,
    // since reading an unwritten coefficient is not allowed: identity camera,
    // identity rotation and zero translation make the pixel just X/Z, Y/Z.
    for (int k = 0; k < CoefCount; k++) begin
      load_coef(k, (k == CamBase || k == CamBase + 4 || k == CamBase + 8 ||
                    k == RotBase || k == RotBase + 4 || k == RotBase + 8) ? One : '0);
    end
    // Loads beyond the store are dropped and must not disturb it.
    load_coef(31, MaxVal);
    load_coef(CoefCount, MinVal);
    project_point(One, 2 * One, One);
    // Negative quotient of -1.5 must truncate toward zero.
    project_point(-3, 5, 2 * One);
    // Zero depth.
    project_point(5 * One, 7 * One, '0);
    // Tiny depth drives both pixels into the clamp, one each way.
    project_point(MaxVal, MinVal, 1);
    project_point(MinVal, MinVal, MinVal);
    project_point(MaxVal, MaxVal, MaxVal);
    // A translation at full scale overflows the rotated point itself.
    load_coef(TransBase + 2, MaxVal);
    project_point('0, '0, MaxVal);
    load_coef(TransBase + 2, '0);
    // The most negative rotation coefficient squared overflows a row.
    load_coef(RotBase, MinVal);
    project_point(MinVal, '0, One);
    load_coef(RotBase, One);

    // Random part: groups of points, each under a freshly loaded pose, now
    // and then a new camera, a partial pose update, or a stray load beyond
    // the store. Stray loads are not counted as they change nothing.
    beats_done = 0;
    while (beats_done < RandomBeats) begin
      calm = (beats_done + CalmBeats > RandomBeats);
      if ($urandom_range(0, 9) == 0) load_coef($urandom_range(CoefCount, 31), $urandom);
      if ($urandom_range(0, 3) == 0) load_camera();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          idx = $urandom_range(RotBase, TransBase + 2);
          load_coef(idx, pick_value(idx >= TransBase ? 20 : 18));
        end
      end else begin
        for (int k = RotBase; k < TransBase; k++) load_coef(k, pick_value(18));
        for (int k = TransBase; k < CoefCount; k++) load_coef(k, pick_value(20));
      end
      repeat ($urandom_range(4, 12)) begin
        if ($urandom_range(0, 15) == 0) project_point('0, '0, '0);
        else project_point(pick_value(22), pick_value(22), pick_value(22));
      end
    end
    in_if.valid <= 1'b0;

    // Wait for the last pixel, then give the core time to show any extra beat.
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Output side: every beat taken at a rising edge is checked, and ready is
  // dropped in random bursts until the calm tail of the run.
  initial begin : result_sink
    int unsigned   stall_left;
    pixel_result_t got;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.pixel_x    = out_if.pixel_x;
        got.pixel_y    = out_if.pixel_y;
        got.zero_depth = out_if.zero_depth;
        got.saturated  = out_if.saturated;
        board.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (calm) stall_left = 0;
      out_if.ready <= (stall_left == 0);
    end
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #(TimeoutTicks);
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/ppp_pkg.sv
src/ppp_if.sv
src/ppp_mac.sv
src/ppp_div.sv
src/pinhole_point_projection_core.sv
bench/pinhole_point_projection_core_tb.sv
